/* rtl/dxt1cd_pkg.sv */
// Shared types, constants and channel arithmetic for the DXT1 colour block decoder.
// No dependencies.
`default_nettype none

package dxt1cd_pkg;

  localparam int DXT1CD_QUEUE_DEPTH = 2;
  localparam int TEXELS = 16;
  localparam logic [3:0] TEXEL_LAST = 4'(TEXELS - 1);
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [1:0] IDX_TRANSPARENT = 2'd3;
  // floor(x/3) == (x * 683) >> 11 for every x below 2048
  localparam logic [19:0] RECIP3 = 20'd683;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } texel_t;

  typedef struct packed {
    texel_t [3:0] palette;
    logic [31:0]  indices;
  } block_t;

  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  // (2a + b + 1) / 3
  function automatic logic [7:0] third_mix(input logic [7:0] a, input logic [7:0] b);
    logic [9:0]  s;
    logic [19:0] p;
    s = {1'b0, a, 1'b0} + {2'b00, b} + 10'd1;
    p = {10'd0, s} * RECIP3;
    return p[18:11];
  endfunction

  // (a + b) / 2
  function automatic logic [7:0] half_mix(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8:1];
  endfunction

endpackage

`default_nettype wire

/* rtl/dxt1cd_front.sv */
// Front end: holds the mode register, unpacks both endpoints and builds the palette.
// Depends on dxt1cd_pkg.
`default_nettype none

module dxt1cd_front import dxt1cd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_data,
  input  wire logic [15:0] endpoint_a,
  input  wire logic [15:0] endpoint_b,
  input  wire logic [31:0] index_word,
  output block_t           entry
);

  logic   dxt1_mode;
  logic   three;
  texel_t ca, cb, c2, c3;

  always_ff @(posedge clk) begin
    if (rst) begin
      dxt1_mode <= 1'b1;
    end else if (cfg_write) begin
      dxt1_mode <= cfg_data;
    end
  end

  always_comb begin
    three = dxt1_mode && (endpoint_a <= endpoint_b);

    ca.red   = widen5(endpoint_a[15:11]);
    ca.green = widen6(endpoint_a[10:5]);
    ca.blue  = widen5(endpoint_a[4:0]);
    ca.alpha = ALPHA_OPAQUE;
    cb.red   = widen5(endpoint_b[15:11]);
    cb.green = widen6(endpoint_b[10:5]);
    cb.blue  = widen5(endpoint_b[4:0]);
    cb.alpha = ALPHA_OPAQUE;

    if (three) begin
      c2.red   = half_mix(ca.red, cb.red);
      c2.green = half_mix(ca.green, cb.green);
      c2.blue  = half_mix(ca.blue, cb.blue);
      c3       = '0;    // transparent black
    end else begin
      c2.red   = third_mix(ca.red, cb.red);
      c2.green = third_mix(ca.green, cb.green);
      c2.blue  = third_mix(ca.blue, cb.blue);
      c3.red   = third_mix(cb.red, ca.red);
      c3.green = third_mix(cb.green, ca.green);
      c3.blue  = third_mix(cb.blue, ca.blue);
      c3.alpha = ALPHA_OPAQUE;
    end
    c2.alpha = ALPHA_OPAQUE;

    entry.palette[0] = ca;
    entry.palette[1] = cb;
    entry.palette[2] = c2;
    entry.palette[IDX_TRANSPARENT] = c3;
    entry.indices = index_word;
  end

endmodule

`default_nettype wire

/* rtl/dxt1cd_queue.sv */
// Small register queue of decoded palettes between the front end and the texel emitter.
// Depends on dxt1cd_pkg.
`default_nettype none

module dxt1cd_queue import dxt1cd_pkg::*; #(
  parameter int DEPTH = DXT1CD_QUEUE_DEPTH
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   wr_en,
  input  wire block_t wr_data,
  output logic        full,
  input  wire logic   rd_en,
  output block_t      rd_data,
  output logic        not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  block_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == FULL_CNT);
  assign not_empty = (count != '0);
  assign rd_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/dxt1cd_back.sv */
// Back end: walks the sixteen indices of the head block and fills the output register.
// Depends on dxt1cd_pkg.
`default_nettype none

module dxt1cd_back import dxt1cd_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   head_valid,
  input  wire block_t head,
  output logic        head_pop,
  output logic        empty,
  input  wire logic   pop,
  output logic [3:0]  texel_number,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha,
  output logic        last_texel
);

  logic [3:0] cnt;
  logic       out_valid;
  logic       advance;
  logic [1:0] sel;
  texel_t     tex;

  assign advance  = head_valid && (!out_valid || pop);
  assign head_pop = advance && (cnt == TEXEL_LAST);
  assign sel      = head.indices[{cnt, 1'b0} +: 2];
  assign tex      = head.palette[sel];
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        cnt       <= cnt + 1'b1;    // wraps to 0 after the last texel
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      texel_number <= cnt;
      red          <= tex.red;
      green        <= tex.green;
      blue         <= tex.blue;
      alpha        <= tex.alpha;
      last_texel   <= (cnt == TEXEL_LAST);
    end
  end

`ifndef ASSERT_OFF
  // a partly emitted block must still sit at the queue head
  a_block_held: assert property (@(posedge clk) disable iff (rst)
    (cnt != '0) |-> head_valid)
    else $error("texel walk in progress without a head block");

  a_wrap: assert property (@(posedge clk) disable iff (rst)
    head_pop |=> (cnt == '0) && out_valid && last_texel)
    else $error("block end did not wrap counter and mark last texel");

  a_output_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> out_valid && $stable(texel_number))
    else $error("unpopped texel lost");
`endif

endmodule

`default_nettype wire

/* rtl/dxt1_colour_block_decoder.sv */
// Top level of the DXT1 colour block decoder: front end, palette queue and texel emitter.
// Depends on dxt1cd_pkg, dxt1cd_front, dxt1cd_queue, dxt1cd_back.
`default_nettype none

// Takes one 8-byte colour block per request and returns its sixteen RGBA8888
// texels in row-major order, one per cycle while pop is held, the last one
// flagged. A block's palette is built in the cycle it is pushed and stored in
// a QUEUE_DEPTH-entry queue; the emitter drains the head block at one texel per
// cycle unless the result side stalls, so the single texel output port sets the
// sustained block rate. The first texel of a block passes through the queue slot
// and then the output register to the result ports if the result side is free.
// cfg_write sets the DXT1 mode bit (reset 1); write it only while the decoder is idle.
module dxt1_colour_block_decoder import dxt1cd_pkg::*; #(
  parameter int QUEUE_DEPTH = DXT1CD_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_data,
  input  wire logic        push,
  output logic             full,
  input  wire logic [15:0] endpoint_a,
  input  wire logic [15:0] endpoint_b,
  input  wire logic [31:0] index_word,
  output logic             empty,
  input  wire logic        pop,
  output logic [3:0]       texel_number,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue,
  output logic [7:0]       alpha,
  output logic             last_texel
);

  block_t entry, head;
  logic   head_valid, head_pop;

  dxt1cd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .endpoint_a (endpoint_a),
    .endpoint_b (endpoint_b),
    .index_word (index_word),
    .entry      (entry)
  );

  dxt1cd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (push && !full),
    .wr_data   (entry),
    .full      (full),
    .rd_en     (head_pop),
    .rd_data   (head),
    .not_empty (head_valid)
  );

  dxt1cd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .head_pop     (head_pop),
    .empty        (empty),
    .pop          (pop),
    .texel_number (texel_number),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .alpha        (alpha),
    .last_texel   (last_texel)
  );

endmodule

`default_nettype wire
